[hw/rtl/rmp_pkg.sv]
// ---------------------------------------------------------------------------
// rmp_pkg: shared types and constants of the multibulk request parser
// Phase codes, character codes, register indexes and the result record.
// ---------------------------------------------------------------------------
package rmp_pkg;

   localparam int ACC_W = 30;
   localparam int CNT_W = 21;
   localparam int IDX_W = 20;

   localparam logic [CNT_W-1:0] COUNT_LIMIT  = 21'd1048576;
   localparam logic [ACC_W-1:0] LENGTH_LIMIT = 30'd536870912;
   localparam logic [ACC_W-1:0] ACC_MAX      = 30'h3FFF_FFFF;

   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic CSR_MAX_ARG_COUNT = 1'b0;
   localparam logic CSR_MAX_BULK_LEN  = 1'b1;

   localparam logic FUNC_DATA    = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   typedef enum logic [3:0] {
      PH_STAR,
      PH_CNT_FIRST,
      PH_CNT_DIGITS,
      PH_CNT_LF,
      PH_DOLLAR,
      PH_LEN_FIRST,
      PH_LEN_DIGITS,
      PH_LEN_LF,
      PH_PAYLOAD,
      PH_PAY_CR,
      PH_PAY_LF,
      PH_ERROR
   } phase_type;

   typedef struct packed {
      logic [CNT_W-1:0] max_arg_count;
      logic [ACC_W-1:0] max_bulk_len;
   } cfg_type;

   typedef struct packed {
      logic             parse_error;
      logic             request_is_null;
      logic             arg_is_null;
      logic             arg_done;
      logic [IDX_W-1:0] arg_index;
      logic [7:0]       payload_byte;
      logic             request_done;
      logic             payload_valid;
   } result_type;

endpackage

[hw/rtl/resp_multibulk_request_parser.sv]
// ---------------------------------------------------------------------------
// resp_multibulk_request_parser: byte-stream multibulk request parser
// Parses star-count and dollar-length framed requests one byte at a time and
// tags each payload byte with its argument index.
//
//   channel  direction  handshake             carries
//   req_     in         req_tvalid/tready     tuser func, tdata byte_value
//   rsp_     out        rsp_tvalid/tready     tuser payload_valid, tlast
//                                             request_done, tdata the rest
//   csr_     in         csr_valid/csr_ready   csr_addr index, csr_data value
//
// One request per cycle unless rsp_ stalls; each result is registered.
// The combinational decode and output register set the rate.
// Reset returns the parser to waiting for a star and both limits to maximum.
// A stalled rsp_ side holds one result and still takes the byte that
// replaces it in the same cycle the result leaves.
// ---------------------------------------------------------------------------
module resp_multibulk_request_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] payload_byte, [27:8] arg_index,
                                    // [28] arg_done, [29] arg_is_null,
                                    // [30] request_is_null, [31] parse_error
   output logic        rsp_tuser,   // [0] payload_valid
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_addr,
   input  logic [29:0] csr_data
);
   import rmp_pkg::*;

   cfg_type    cfg;
   result_type step_result;
   result_type held_result;
   logic       fire;

   assign fire = req_tvalid && req_tready;

   rmp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rmp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .func       (req_tuser),
      .byte_value (req_tdata),
      .cfg        (cfg),
      .result     (step_result)
   );

   rmp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_result  (step_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (held_result)
   );

   assign rsp_tdata = {held_result.parse_error, held_result.request_is_null,
                       held_result.arg_is_null, held_result.arg_done,
                       held_result.arg_index, held_result.payload_byte};
   assign rsp_tuser = held_result.payload_valid;
   assign rsp_tlast = held_result.request_done;

`ifndef ASSERT_OFF
   a_null_arg_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[29] |-> rsp_tdata[28])
      else $error("null argument flagged without argument completion");

   a_null_req_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[30] |-> rsp_tlast)
      else $error("null request flagged without request completion");

   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31] |-> !rsp_tuser && !rsp_tdata[28] && !rsp_tlast)
      else $error("error result carries payload or completion");
`endif

endmodule

[hw/rtl/rmp_csr.sv]
// ---------------------------------------------------------------------------
// rmp_csr: limit registers of the multibulk request parser
// Holds the argument count and bulk length limits written over the CSR port.
// ---------------------------------------------------------------------------
module rmp_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_addr,
   input  logic [29:0]      csr_data,
   output rmp_pkg::cfg_type cfg
);
   import rmp_pkg::*;

   logic [CNT_W-1:0] max_arg_count_ff;
   logic [CNT_W-1:0] max_arg_count_in;
   logic [ACC_W-1:0] max_bulk_len_ff;
   logic [ACC_W-1:0] max_bulk_len_in;

   assign csr_ready = 1'b1;

   always_comb begin
      max_arg_count_in = max_arg_count_ff;
      max_bulk_len_in  = max_bulk_len_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            CSR_MAX_ARG_COUNT: max_arg_count_in = csr_data[CNT_W-1:0];
            CSR_MAX_BULK_LEN:  max_bulk_len_in  = csr_data[ACC_W-1:0];
            default:           max_bulk_len_in  = max_bulk_len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_arg_count_ff <= COUNT_LIMIT;
         max_bulk_len_ff  <= LENGTH_LIMIT;
      end else begin
         max_arg_count_ff <= max_arg_count_in;
         max_bulk_len_ff  <= max_bulk_len_in;
      end
   end

   assign cfg.max_arg_count = max_arg_count_ff;
   assign cfg.max_bulk_len  = max_bulk_len_ff;

endmodule

[hw/rtl/rmp_parse.sv]
// ---------------------------------------------------------------------------
// rmp_parse: parser state and per-byte decode
// Advances the phase, number accumulator and argument counters on each
// accepted request and forms the matching result record.
// ---------------------------------------------------------------------------
module rmp_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                func,
   input  logic [7:0]          byte_value,
   input  rmp_pkg::cfg_type    cfg,
   output rmp_pkg::result_type result
);
   import rmp_pkg::*;

   phase_type        phase_ff, phase_in;
   logic             neg_ff, neg_in;
   logic [ACC_W-1:0] accum_ff, accum_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic [ACC_W-1:0] left_ff, left_in;

   logic [ACC_W+3:0] acc_sum;
   logic [ACC_W-1:0] acc_sat;
   logic             is_digit;
   logic             first;
   logic [CNT_W-1:0] seen_next;
   logic             last_arg;
   logic [ACC_W-1:0] left_dec;
   logic             err;

   assign acc_sum  = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1)
                   + {{ACC_W{1'b0}}, byte_value[3:0]};
   assign acc_sat  = (acc_sum > {4'b0, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];
   assign is_digit = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
   assign first    = (phase_ff == PH_CNT_FIRST) || (phase_ff == PH_LEN_FIRST);
   assign seen_next = seen_ff + 1'b1;
   assign last_arg  = (seen_next >= total_ff);
   assign left_dec  = (left_ff != '0) ? left_ff - 1'b1 : '0;

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      accum_in = accum_ff;
      total_in = total_ff;
      seen_in  = seen_ff;
      left_in  = left_ff;
      result   = '0;
      err      = 1'b0;
      if (func == FUNC_RESTART) begin
         phase_in = PH_STAR;
         neg_in   = 1'b0;
         accum_in = '0;
         total_in = '0;
         seen_in  = '0;
         left_in  = '0;
      end else begin
         if (phase_ff >= PH_DOLLAR && phase_ff <= PH_PAY_LF) begin
            result.arg_index = seen_ff[IDX_W-1:0];
         end
         unique case (phase_ff)
            PH_STAR, PH_DOLLAR: begin
               if ((phase_ff == PH_STAR && byte_value == CH_STAR) ||
                   (phase_ff == PH_DOLLAR && byte_value == CH_DOLLAR)) begin
                  neg_in   = 1'b0;
                  accum_in = '0;
                  phase_in = (phase_ff == PH_STAR) ? PH_CNT_FIRST : PH_LEN_FIRST;
               end else begin
                  err = 1'b1;
               end
            end
            PH_CNT_FIRST, PH_CNT_DIGITS, PH_LEN_FIRST, PH_LEN_DIGITS: begin
               priority if (is_digit) begin
                  accum_in = acc_sat;
                  phase_in = (phase_ff <= PH_CNT_DIGITS) ? PH_CNT_DIGITS : PH_LEN_DIGITS;
               end else if (first && byte_value == CH_MINUS) begin
                  neg_in   = 1'b1;
                  phase_in = (phase_ff <= PH_CNT_DIGITS) ? PH_CNT_DIGITS : PH_LEN_DIGITS;
               end else if (first && byte_value == CH_PLUS) begin
                  phase_in = (phase_ff <= PH_CNT_DIGITS) ? PH_CNT_DIGITS : PH_LEN_DIGITS;
               end else if (byte_value == CH_CR) begin
                  phase_in = (phase_ff <= PH_CNT_DIGITS) ? PH_CNT_LF : PH_LEN_LF;
               end else begin
                  err = 1'b1;
               end
            end
            PH_CNT_LF: begin
               priority if (byte_value != CH_LF) begin
                  err = 1'b1;
               end else if (neg_ff && accum_ff == 30'd1) begin
                  result.request_done    = 1'b1;
                  result.request_is_null = 1'b1;
                  phase_in = PH_STAR;
                  neg_in   = 1'b0;
                  accum_in = '0;
                  total_in = '0;
                  seen_in  = '0;
                  left_in  = '0;
               end else if (neg_ff && accum_ff > 30'd1) begin
                  err = 1'b1;
               end else if (accum_ff > {9'b0, cfg.max_arg_count} ||
                            accum_ff > {9'b0, COUNT_LIMIT}) begin
                  err = 1'b1;
               end else if (accum_ff == '0) begin
                  result.request_done = 1'b1;
                  phase_in = PH_STAR;
                  neg_in   = 1'b0;
                  total_in = '0;
                  seen_in  = '0;
                  left_in  = '0;
               end else begin
                  total_in = accum_ff[CNT_W-1:0];
                  seen_in  = '0;
                  phase_in = PH_DOLLAR;
               end
            end
            PH_LEN_LF: begin
               priority if (byte_value != CH_LF) begin
                  err = 1'b1;
               end else if (neg_ff && accum_ff == 30'd1) begin
                  result.arg_done    = 1'b1;
                  result.arg_is_null = 1'b1;
                  if (last_arg) begin
                     result.request_done = 1'b1;
                     phase_in = PH_STAR;
                     neg_in   = 1'b0;
                     accum_in = '0;
                     total_in = '0;
                     seen_in  = '0;
                     left_in  = '0;
                  end else begin
                     seen_in  = seen_next;
                     phase_in = PH_DOLLAR;
                  end
               end else if (neg_ff && accum_ff > 30'd1) begin
                  err = 1'b1;
               end else if (accum_ff > cfg.max_bulk_len || accum_ff > LENGTH_LIMIT) begin
                  err = 1'b1;
               end else if (accum_ff == '0) begin
                  phase_in = PH_PAY_CR;
               end else begin
                  left_in  = accum_ff;
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               result.payload_valid = 1'b1;
               result.payload_byte  = byte_value;
               left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = PH_PAY_CR;
               end
            end
            PH_PAY_CR: begin
               if (byte_value == CH_CR) begin
                  phase_in = PH_PAY_LF;
               end else begin
                  err = 1'b1;
               end
            end
            PH_PAY_LF: begin
               if (byte_value == CH_LF) begin
                  result.arg_done = 1'b1;
                  if (last_arg) begin
                     result.request_done = 1'b1;
                     phase_in = PH_STAR;
                     neg_in   = 1'b0;
                     accum_in = '0;
                     total_in = '0;
                     seen_in  = '0;
                     left_in  = '0;
                  end else begin
                     seen_in  = seen_next;
                     phase_in = PH_DOLLAR;
                  end
               end else begin
                  err = 1'b1;
               end
            end
            default: begin
               err = 1'b1;
            end
         endcase
         if (err) begin
            phase_in = PH_ERROR;
            neg_in   = 1'b0;
            accum_in = '0;
            total_in = '0;
            seen_in  = '0;
            left_in  = '0;
            result.payload_valid   = 1'b0;
            result.payload_byte    = '0;
            result.arg_done        = 1'b0;
            result.arg_is_null     = 1'b0;
            result.request_done    = 1'b0;
            result.request_is_null = 1'b0;
            result.parse_error     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STAR;
         neg_ff   <= 1'b0;
         accum_ff <= '0;
         total_ff <= '0;
         seen_ff  <= '0;
         left_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         accum_ff <= accum_in;
         total_ff <= total_in;
         seen_ff  <= seen_in;
         left_ff  <= left_in;
      end
   end

`ifndef ASSERT_OFF
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      fire && func == FUNC_RESTART |=> phase_ff == PH_STAR && seen_ff == '0 && total_ff == '0)
      else $error("restart did not clear the parser");

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> left_ff != '0)
      else $error("payload phase with no bytes left");

   a_args_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff >= PH_DOLLAR && phase_ff <= PH_PAY_LF |-> total_ff != '0 && seen_ff < total_ff)
      else $error("argument counter outside the request count");

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      fire && result.request_done |=> phase_ff == PH_STAR && seen_ff == '0)
      else $error("parser did not rearm after a completed request");
`endif

endmodule

[hw/rtl/rmp_out_reg.sv]
// ---------------------------------------------------------------------------
// rmp_out_reg: result holding register
// Holds one result until the downstream side takes it; refills in the same
// cycle the held result leaves.
// ---------------------------------------------------------------------------
module rmp_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rmp_pkg::result_type in_result,
   output logic                out_valid,
   input  logic                out_ready,
   output rmp_pkg::result_type out_result
);
   import rmp_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (in_ready) begin
         valid_in  = in_valid;
         result_in = in_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule
